### design/replay_window_filter_core_macros.svh
// Assertion helpers for the RTL.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef REPLAY_WINDOW_FILTER_CORE_MACROS_SVH
`define REPLAY_WINDOW_FILTER_CORE_MACROS_SVH

// Same-cycle implication
`define RWF_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define RWF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/rwf_pkg.sv
package rwf_pkg;

  // Request kinds
  typedef enum logic {
    OP_TEST = 1'b0,
    OP_ADD  = 1'b1
  } op_t;

  // Request as held between the front queue and the window engine
  typedef struct packed {
    op_t         op;
    logic [63:0] seq;
  } item_t;

  // Front to back: head of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // Register map
  localparam int unsigned CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_AHEAD_LIMIT = 2'd0;
  localparam logic [31:0] AHEAD_LIMIT_RST = 32'd1024;

  // Front queue depth
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

endpackage

### design/rwf_item_if.sv
interface rwf_item_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] seq_number;

  modport source (output valid, output operation, output seq_number, input ready);
  modport sink   (input valid, input operation, input seq_number, output ready);
endinterface

### design/rwf_result_if.sv
interface rwf_result_if;
  logic valid;
  logic ready;
  logic is_replay;

  modport source (output valid, output is_replay, input ready);
  modport sink   (input valid, input is_replay, output ready);
endinterface

### design/rwf_front.sv
module rwf_front (
  input  logic           clk,
  input  logic           rst_n,
  rwf_item_if.sink       in_ch,
  output rwf_pkg::head_t head,
  input  logic           pop
);
  import rwf_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    count_r, count_nxt;
  logic              push;
  logic              do_pop;
  item_t             in_item;

  // decode incoming request
  assign in_item.op  = op_t'(in_ch.operation);
  assign in_item.seq = in_ch.seq_number;

  assign in_ch.ready = (count_r != QCW'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

### design/rwf_engine.sv
`include "replay_window_filter_core_macros.svh"

module rwf_engine #(
  parameter int unsigned WIN_LEN = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rwf_pkg::head_t head,
  output logic           pop,
  input  logic [31:0]    ahead_limit,
  rwf_result_if.source   out_ch
);
  import rwf_pkg::*;

  localparam int unsigned IW = $clog2(WIN_LEN);

  logic [63:0]        base_r, base_nxt;
  logic [WIN_LEN-1:0] bitmap_r, bitmap_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_replay_r, out_replay_nxt;

  logic [63:0]   offset;
  logic [IW-1:0] shift_amt;
  logic [63:0]   slide_base;
  logic [63:0]   limit_top;
  logic          in_win;
  logic          far;
  logic          bit_seen;
  logic          replay;
  logic          pop_test;
  logic          pop_add;
  logic          pop_slide;

  // take the head when the result register is free or being drained
  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  assign pop_test  = pop && (head.item.op == OP_TEST);
  assign pop_add   = pop && (head.item.op == OP_ADD);
  assign pop_slide = pop_add && !in_win;

  // window position of the request
  assign offset     = head.item.seq - base_r;
  assign in_win     = (offset < 64'(WIN_LEN));
  // slide distance is offset - WIN_LEN + 1; only needed below WIN_LEN
  assign shift_amt  = offset[IW-1:0] - IW'(WIN_LEN - 1);
  assign far        = (offset >= 64'(2 * WIN_LEN - 1));
  // after a slide the number sits on the top bit
  assign slide_base = head.item.seq - 64'(WIN_LEN - 1);
  assign limit_top  = 64'(WIN_LEN) + {32'd0, ahead_limit};
  assign bit_seen   = in_win ? bitmap_r[offset[IW-1:0]] : 1'b0;

  // verdict for a test
  always_comb begin
    replay = 1'b0;
    if (head.item.op == OP_TEST) begin
      replay = in_win ? bit_seen : (offset >= limit_top);
    end
  end

  // window update on an add
  always_comb begin
    base_nxt   = base_r;
    bitmap_nxt = bitmap_r;
    if (pop && head.item.op == OP_ADD) begin
      if (in_win) begin
        bitmap_nxt[offset[IW-1:0]] = 1'b1;
      end else begin
        base_nxt   = slide_base;
        bitmap_nxt = far ? '0 : (bitmap_r >> shift_amt);
        bitmap_nxt[WIN_LEN-1] = 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_replay_nxt = out_replay_r;
    if (pop) begin
      out_valid_nxt  = 1'b1;
      out_replay_nxt = replay;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      bitmap_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      bitmap_r    <= bitmap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_replay_r <= out_replay_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.is_replay = out_replay_r;

  // checks
  `RWF_ASSERT_NEXT(a_test_hold, pop_test, $stable({base_r, bitmap_r}), "test moved window")
  `RWF_ASSERT_NEXT(a_add_never_replay, pop_add, out_valid_r && !out_replay_r, "add gave replay")
  `RWF_ASSERT_NEXT(a_slide_top_bit, pop_slide, bitmap_r[WIN_LEN-1], "top bit not set")
  `RWF_ASSERT_NEXT(a_slide_base, pop_slide, base_r == $past(slide_base), "base not moved")
  `RWF_ASSERT_SAME(a_hold_blocks_pop, out_valid_r && !out_ch.ready, !pop, "pop while held")

endmodule

### design/replay_window_filter_core.sv
// Channel  Dir  Payload                          Handshake
// in_ch    in   operation, seq_number[63:0]      valid / ready
// out_ch   out  is_replay                        valid / ready
// cfg_*    in   ahead_limit[31:0] at address 0   APB read/write, pready tied high
//
// One request per cycle sustained while out_ch is ready; a taken request is held in a
// queue slot, then the offset, compare and window shift feed the result register.
// Synchronous reset clears the window base and bitmap and loads ahead_limit with
// 1024; there is no clearing pass, requests are taken right after reset.
// A two-entry queue ahead of the engine keeps in_ch ready while a result waits, until it fills.
module replay_window_filter_core #(
  parameter int unsigned WIN_LEN = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rwf_item_if.sink                  in_ch,
  rwf_result_if.source              out_ch,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [rwf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]               cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);
  import rwf_pkg::*;

  logic [31:0] ahead_limit_r, ahead_limit_nxt;
  logic        cfg_wr;
  head_t       head;
  logic        pop;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == REG_AHEAD_LIMIT);

  always_comb begin
    ahead_limit_nxt = ahead_limit_r;
    if (cfg_wr) begin
      ahead_limit_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ahead_limit_r <= AHEAD_LIMIT_RST;
    end else begin
      ahead_limit_r <= ahead_limit_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr == REG_AHEAD_LIMIT) ? ahead_limit_r : 32'd0;

  // front: accept and queue
  rwf_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // back: window check and update
  rwf_engine #(
    .WIN_LEN (WIN_LEN)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .ahead_limit (ahead_limit_r),
    .out_ch      (out_ch)
  );

endmodule

### bench/replay_window_filter_core_test.sv
`timescale 1ns / 100ps

module replay_window_filter_core_test;
  import rwf_pkg::*;

  localparam int unsigned WIN_LEN      = 256;
  localparam int unsigned PIPE_LAT     = 4;     // extra wait in drain_window after the last result
  localparam int unsigned STUCK_LIMIT  = 5000;  // cycles with no handshake anywhere
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned RANDOM_BATCH = 200;

  typedef struct {
    op_t         op;
    logic [63:0] seq;
    logic        replay;
  } verdict_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  rwf_item_if   req_if ();
  rwf_result_if res_if ();

  replay_window_filter_core #(
    .WIN_LEN (WIN_LEN)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (req_if),
    .out_ch      (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Tracked window state
  logic [63:0]        track_base;
  logic [WIN_LEN-1:0] track_seen;
  logic [31:0]        track_ahead;

  verdict_t verdict_q[$];

  int   send_idle_pct;
  int   recv_stall_pct;
  int   mismatches;
  int   stuck_cycles;
  logic hold_active;
  event hold_kick;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Window tracking: returns the verdict for one request and updates the window on an add
  function automatic logic predict_verdict(input op_t op, input logic [63:0] seq);
    logic [63:0] offset;
    logic [63:0] advance;
    logic        verdict;
    offset  = seq - track_base;
    verdict = 1'b0;
    if (op == OP_TEST) begin
      if (offset < WIN_LEN)
        verdict = track_seen[offset];
      else
        verdict = (offset >= 64'(WIN_LEN) + {32'd0, track_ahead});
    end else if (offset < WIN_LEN) begin
      track_seen[offset] = 1'b1;
    end else begin
      // slide the window so that seq lands on the top bit
      advance    = offset - WIN_LEN + 1;
      track_base = track_base + advance;
      if (advance >= WIN_LEN)
        track_seen = '0;
      else
        track_seen = track_seen >> advance;
      track_seen[WIN_LEN-1] = 1'b1;
    end
    return verdict;
  endfunction

  // Sequence numbers aimed around the current window
  function automatic logic [63:0] pick_seq();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55)
      return track_base + $urandom_range(WIN_LEN - 1);
    else if (r < 70)
      return track_base + WIN_LEN + $urandom_range(80);
    else if (r < 80)
      return track_base + WIN_LEN + track_ahead + $urandom_range(3) - 2;
    else if (r < 88)
      return track_base - $urandom_range(300, 1);
    else if (r < 94)
      return {$urandom, $urandom};
    else
      return track_base + WIN_LEN + $urandom_range(5000, 256);
  endfunction

  function automatic op_t pick_op();
    return ($urandom_range(99) < 40) ? OP_ADD : OP_TEST;
  endfunction

  // Offer one request; returns at the edge where it is taken
  task automatic offer_request(input op_t op, input logic [63:0] seq);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.seq_number <= seq;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    v.op     = op;
    v.seq    = seq;
    v.replay = predict_verdict(op, seq);
    verdict_q.push_back(v);
  endtask

  // One APB transfer to the ahead limit; a read is checked against the tracked value
  task automatic apb_access(input logic wr, input logic [31:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= REG_AHEAD_LIMIT;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (wr) begin
      track_ahead = wdata;
    end else if (cfg_prdata !== track_ahead) begin
      mismatches++;
      $display("%0t: ahead_limit readback mismatch, expected %0h, actual %0h",
               $time, track_ahead, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every outstanding result is back and the pipeline is empty
  task automatic drain_window();
    req_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic test_reset_state();
    apb_access(1'b0, 32'd0);
  endtask

  // Window edges, ahead boundary, wrap of the base and numbers behind it
  task automatic test_directed_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    offer_request(OP_TEST, 64'd0);
    offer_request(OP_ADD,  64'd0);
    offer_request(OP_TEST, 64'd0);
    offer_request(OP_ADD,  64'd255);
    offer_request(OP_TEST, 64'd255);
    offer_request(OP_TEST, 64'd1);
    offer_request(OP_TEST, 64'd256);
    offer_request(OP_TEST, track_base + WIN_LEN + track_ahead - 1);
    offer_request(OP_TEST, track_base + WIN_LEN + track_ahead);
    offer_request(OP_TEST, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_request(OP_ADD,  64'd256);
    offer_request(OP_TEST, 64'd0);
    offer_request(OP_ADD,  64'd300);
    offer_request(OP_TEST, 64'd255);
    offer_request(OP_ADD,  track_base + 2 * WIN_LEN - 1);
    offer_request(OP_TEST, track_base + WIN_LEN - 2);
    offer_request(OP_ADD,  64'hFFFF_FFFF_FFFF_FFFF);
    offer_request(OP_TEST, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_request(OP_ADD,  64'd0);
    offer_request(OP_TEST, 64'd0);
    offer_request(OP_ADD,  64'h5555_5555_AAAA_AAAA);
    offer_request(OP_ADD,  track_base - 1);
    offer_request(OP_TEST, 64'hAAAA_AAAA_5555_5555);
  endtask

  // Receiver holds off while requests keep coming, so the input queue fills
  task automatic test_backpressure_fill();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_kick;
    repeat (30) offer_request(pick_op(), pick_seq());
  endtask

  task automatic test_random_mix(input int count, input int send_idle, input int stall,
                                 input logic [31:0] ahead);
    drain_window();
    apb_access(1'b1, ahead);
    apb_access(1'b0, 32'd0);
    send_idle_pct  = send_idle;
    recv_stall_pct = stall;
    repeat (count) offer_request(pick_op(), pick_seq());
  endtask

  // Long receiver hold-off, counted here
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_kick);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Result check and receiver ready
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending, expected none, actual is_replay %0b",
                 $time, res_if.is_replay);
      end else begin
        want = verdict_q.pop_front();
        if (res_if.is_replay !== want.replay) begin
          mismatches++;
          $display("%0t: is_replay mismatch for op %s seq %h, expected %0b, actual %0b",
                   $time, want.op.name(), want.seq, want.replay, res_if.is_replay);
        end
      end
    end
    if (hold_active)
      res_if.ready <= 1'b0;
    else
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = 1'b0;
    req_if.seq_number = '0;
    res_if.ready      = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = REG_AHEAD_LIMIT;
    cfg_pwdata        = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatches        = 0;
    stuck_cycles      = 0;
    track_base        = '0;
    track_seen        = '0;
    track_ahead       = AHEAD_LIMIT_RST;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_edges();
    test_backpressure_fill();
    test_random_mix(RANDOM_BATCH, 0, 0, AHEAD_LIMIT_RST);
    test_random_mix(RANDOM_BATCH, 67, 0, 32'd0);
    test_random_mix(RANDOM_BATCH, 0, 67, 32'hFFFF_FFFF);
    test_random_mix(RANDOM_BATCH, 31, 31, $urandom);
    test_random_mix(RANDOM_BATCH, 0, 0, 32'd3);
    drain_window();

    if (mismatches == 0 && verdict_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
